// File: hw/rtl/jptp_pkg.sv
`default_nettype none

package jptp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_ERROR     = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NO_SLASH       = 2'd0,
    ERR_DANGLING_TILDE = 2'd1,
    ERR_BAD_ESCAPE     = 2'd2
  } err_e;

  // Characters of the pointer syntax
  localparam logic [7:0] CharTilde = 8'h7E;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDash  = 8'h2D;

  // Parameter defaults
  localparam int unsigned IndexBitsDef  = 32;
  localparam int unsigned OffsetBitsDef = 16;

  // Result queue geometry
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = 3;

  // One result beat
  typedef struct packed {
    kind_e        kind;
    logic [7:0]   out_byte;
    logic [15:0]  token_number;
    logic         index_ok;
    logic [31:0]  index_value;
    err_e         error_code;
    logic [15:0]  error_offset;
    logic         last;
  } res_t;

  // Results pushed by the parser in one cycle
  typedef struct packed {
    logic         pend;   // an item sits in the input register
    logic [1:0]   cnt;    // results pushed this cycle
    res_t [1:0]   res;    // res[0] goes first
  } push_t;

  function automatic res_t make_byte(input logic [7:0] ch, input logic [15:0] tnum);
    res_t r;
    r              = '0;
    r.kind         = KIND_BYTE;
    r.out_byte     = ch;
    r.token_number = tnum;
    return r;
  endfunction

  function automatic res_t make_err(input err_e code, input logic [15:0] off,
                                    input logic [15:0] tnum);
    res_t r;
    r              = '0;
    r.kind         = KIND_ERROR;
    r.token_number = tnum;
    r.error_code   = code;
    r.error_offset = off;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic res_t make_empty();
    res_t r;
    r      = '0;
    r.kind = KIND_EMPTY;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/json_pointer_token_parser_unit.sv
// Result path: an accepted input beat passes through the input register, then its results
// pass through the result queue before they are valid.
// Throughput: one input beat per cycle unless in_stall_o is high; one result beat leaves per
// cycle unless out_stall_i is high, so beats that give two results (byte or slash at end
// of text) leave as two result beats. The 8-entry result queue sets when input stalls.
// Reset (rst_ni low, asynchronous) clears the parser state and empties the queue.
`default_nettype none

module json_pointer_token_parser_unit #(
  parameter int unsigned INDEX_BITS  = jptp_pkg::IndexBitsDef,
  parameter int unsigned OFFSET_BITS = jptp_pkg::OffsetBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      token_number_o,
  output logic             index_ok_o,
  output logic [31:0]      index_value_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      error_offset_o,
  output logic             last_o
);

  localparam int unsigned LvlW = jptp_pkg::FifoPtrW + 2;

  jptp_pkg::push_t                 push;
  jptp_pkg::res_t                  head;
  logic [jptp_pkg::FifoPtrW:0]     level;
  logic [LvlW-1:0]                 booked;
  logic                            take;

  // Room for the beat in flight and the next one, two results each
  assign booked     = LvlW'(level) + (push.pend ? LvlW'(2) : LvlW'(0));
  assign in_stall_o = booked > LvlW'(jptp_pkg::FifoDepth - 2);
  assign take       = in_valid_i && !in_stall_o;

  jptp_core #(
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .text_byte_i    (text_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_text_i  (end_of_text_i),
    .push_o         (push)
  );

  jptp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .level_o     (level)
  );

  assign kind_o         = head.kind;
  assign out_byte_o     = head.out_byte;
  assign token_number_o = head.token_number;
  assign index_ok_o     = head.index_ok;
  assign index_value_o  = head.index_value;
  assign error_code_o   = head.error_code;
  assign error_offset_o = head.error_offset;
  assign last_o         = head.last;

endmodule

`default_nettype wire

// File: hw/rtl/jptp_core.sv
`default_nettype none

module jptp_core #(
  parameter int unsigned INDEX_BITS  = jptp_pkg::IndexBitsDef,
  parameter int unsigned OFFSET_BITS = jptp_pkg::OffsetBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      text_byte_i,
  input  wire logic            byte_present_i,
  input  wire logic            end_of_text_i,
  output jptp_pkg::push_t      push_o
);

  localparam int unsigned OffW = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
  localparam int unsigned WideW = INDEX_BITS + 4;

  // First-byte classes of a token
  localparam logic [1:0] FzdNone = 2'd0;
  localparam logic [1:0] FzdZero = 2'd1;
  localparam logic [1:0] FzdDash = 2'd2;

  // Input register
  logic        pv_q, pv_d;
  logic [7:0]  byte_q;
  logic        pres_q, eot_q;

  // Parser state
  logic                  started_q, started_d;
  logic                  tilde_q, tilde_d;
  logic                  skip_q, skip_d;
  logic [OffW-1:0]       off_q, off_d;
  logic [15:0]           tcnt_q, tcnt_d;
  logic [1:0]            tlen_q, tlen_d;
  logic [1:0]            fzd_q, fzd_d;
  logic                  adno_q, adno_d;
  logic [INDEX_BITS-1:0] acc_q, acc_d;

  // Token state after taking one more byte
  logic [7:0]            feed_ch;
  logic                  is_digit;
  logic [WideW-1:0]      wide;
  logic                  ovf;
  logic [1:0]            tlen_f, fzd_f;
  logic                  adno_f;
  logic [INDEX_BITS-1:0] acc_f;

  // Saturated offsets and token count
  logic [OffW:0]         off_sum1, off_sum2;
  logic [OffW-1:0]       off_inc1, off_inc2;
  logic [15:0]           tcnt_inc;
  logic [15:0]           off16;

  // Result builders
  jptp_pkg::res_t        res0, res1;
  logic [1:0]            nres;
  logic                  clr, set_skip;

  function automatic jptp_pkg::res_t tok_res(input logic [1:0] len, input logic [1:0] fzd,
                                             input logic adno,
                                             input logic [INDEX_BITS-1:0] acc,
                                             input logic [15:0] tnum, input logic lst);
    jptp_pkg::res_t r;
    logic           ok;
    ok             = (len != 2'd0) && adno && !((len == 2'd2) && (fzd == FzdZero));
    r              = '0;
    r.kind         = jptp_pkg::KIND_TOKEN_END;
    r.token_number = tnum;
    r.index_ok     = ok;
    r.index_value  = ok ? 32'(acc) : 32'd0;
    r.last         = lst;
    return r;
  endfunction

  // Byte fed to the index check: decoded escape or the plain byte
  always_comb begin
    if (tilde_q) begin
      feed_ch = (byte_q == jptp_pkg::CharZero) ? jptp_pkg::CharTilde : jptp_pkg::CharSlash;
    end else begin
      feed_ch = byte_q;
    end
    is_digit = (feed_ch >= jptp_pkg::CharZero) && (feed_ch <= jptp_pkg::CharNine);
    // acc * 10 + digit as shift-add
    wide = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + WideW'(feed_ch[3:0]);
    ovf  = |wide[WideW-1:INDEX_BITS];
    tlen_f = (tlen_q == 2'd2) ? 2'd2 : tlen_q + 2'd1;
    if (tlen_q == 2'd0) begin
      fzd_f = (feed_ch == jptp_pkg::CharZero) ? FzdZero :
              ((feed_ch == jptp_pkg::CharDash) ? FzdDash : FzdNone);
    end else begin
      fzd_f = fzd_q;
    end
    adno_f = adno_q && is_digit && !ovf;
    acc_f  = adno_f ? wide[INDEX_BITS-1:0] : acc_q;
  end

  // Saturating counters
  assign off_sum1 = {1'b0, off_q} + (OffW+1)'(1);
  assign off_sum2 = {1'b0, off_q} + (OffW+1)'(2);
  assign off_inc1 = off_sum1[OffW] ? {OffW{1'b1}} : off_sum1[OffW-1:0];
  assign off_inc2 = off_sum2[OffW] ? {OffW{1'b1}} : off_sum2[OffW-1:0];
  assign tcnt_inc = (tcnt_q == 16'hFFFF) ? tcnt_q : tcnt_q + 16'd1;
  assign off16    = 16'(off_q);

  // Parse the registered beat
  always_comb begin
    pv_d      = take_i;
    started_d = started_q;
    tilde_d   = tilde_q;
    skip_d    = skip_q;
    off_d     = off_q;
    tcnt_d    = tcnt_q;
    tlen_d    = tlen_q;
    fzd_d     = fzd_q;
    adno_d    = adno_q;
    acc_d     = acc_q;
    res0      = '0;
    res1      = '0;
    nres      = 2'd0;
    clr       = 1'b0;
    set_skip  = 1'b0;

    if (pv_q) begin
      priority if (skip_q) begin
        clr = eot_q;
      end else if (!started_q) begin
        if (!pres_q) begin
          res0     = jptp_pkg::make_empty();
          nres     = 2'd1;
          clr      = 1'b1;
          set_skip = !eot_q;
        end else if (byte_q != jptp_pkg::CharSlash) begin
          res0     = jptp_pkg::make_err(jptp_pkg::ERR_NO_SLASH, 16'd0, tcnt_q);
          nres     = 2'd1;
          clr      = 1'b1;
          set_skip = !eot_q;
        end else if (eot_q) begin
          // lone slash: one empty token
          res0 = tok_res(2'd0, FzdNone, 1'b1, '0, 16'd0, 1'b1);
          nres = 2'd1;
          clr  = 1'b1;
        end else begin
          started_d = 1'b1;
          tilde_d   = 1'b0;
          skip_d    = 1'b0;
          off_d     = OffW'(1);
          tcnt_d    = 16'd0;
          tlen_d    = 2'd0;
          fzd_d     = FzdNone;
          adno_d    = 1'b1;
          acc_d     = '0;
        end
      end else if (!pres_q) begin
        // no byte; may close the text
        if (eot_q) begin
          if (tilde_q) begin
            res0 = jptp_pkg::make_err(jptp_pkg::ERR_DANGLING_TILDE, off16, tcnt_q);
          end else begin
            res0 = tok_res(tlen_q, fzd_q, adno_q, acc_q, tcnt_q, 1'b1);
          end
          nres = 2'd1;
          clr  = 1'b1;
        end
      end else if (tilde_q) begin
        if ((byte_q == jptp_pkg::CharZero) || (byte_q == jptp_pkg::CharOne)) begin
          res0 = jptp_pkg::make_byte(feed_ch, tcnt_q);
          if (eot_q) begin
            res1 = tok_res(tlen_f, fzd_f, adno_f, acc_f, tcnt_q, 1'b1);
            nres = 2'd2;
            clr  = 1'b1;
          end else begin
            nres    = 2'd1;
            tilde_d = 1'b0;
            off_d   = off_inc2;
            tlen_d  = tlen_f;
            fzd_d   = fzd_f;
            adno_d  = adno_f;
            acc_d   = acc_f;
          end
        end else begin
          res0 = jptp_pkg::make_err((byte_q == jptp_pkg::CharSlash) ?
                                    jptp_pkg::ERR_DANGLING_TILDE : jptp_pkg::ERR_BAD_ESCAPE,
                                    off16, tcnt_q);
          nres     = 2'd1;
          clr      = 1'b1;
          set_skip = !eot_q;
        end
      end else if (byte_q == jptp_pkg::CharSlash) begin
        res0 = tok_res(tlen_q, fzd_q, adno_q, acc_q, tcnt_q, 1'b0);
        if (eot_q) begin
          // trailing slash closes an empty token too
          res1 = tok_res(2'd0, FzdNone, 1'b1, '0, tcnt_inc, 1'b1);
          nres = 2'd2;
          clr  = 1'b1;
        end else begin
          nres   = 2'd1;
          tcnt_d = tcnt_inc;
          tlen_d = 2'd0;
          fzd_d  = FzdNone;
          adno_d = 1'b1;
          acc_d  = '0;
          off_d  = off_inc1;
        end
      end else if (byte_q == jptp_pkg::CharTilde) begin
        if (eot_q) begin
          res0 = jptp_pkg::make_err(jptp_pkg::ERR_DANGLING_TILDE, off16, tcnt_q);
          nres = 2'd1;
          clr  = 1'b1;
        end else begin
          tilde_d = 1'b1;
        end
      end else begin
        res0 = jptp_pkg::make_byte(byte_q, tcnt_q);
        if (eot_q) begin
          res1 = tok_res(tlen_f, fzd_f, adno_f, acc_f, tcnt_q, 1'b1);
          nres = 2'd2;
          clr  = 1'b1;
        end else begin
          nres   = 2'd1;
          off_d  = off_inc1;
          tlen_d = tlen_f;
          fzd_d  = fzd_f;
          adno_d = adno_f;
          acc_d  = acc_f;
        end
      end
    end

    // End of text, error or empty marker: back to the start state
    if (clr) begin
      started_d = 1'b0;
      tilde_d   = 1'b0;
      skip_d    = set_skip;
      off_d     = '0;
      tcnt_d    = 16'd0;
      tlen_d    = 2'd0;
      fzd_d     = FzdNone;
      adno_d    = 1'b1;
      acc_d     = '0;
    end
  end

  assign push_o.pend   = pv_q;
  assign push_o.cnt    = nres;
  assign push_o.res[0] = res0;
  assign push_o.res[1] = res1;

  // Control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= 1'b0;
      started_q <= 1'b0;
      tilde_q   <= 1'b0;
      skip_q    <= 1'b0;
      off_q     <= '0;
      tcnt_q    <= 16'd0;
      tlen_q    <= 2'd0;
      fzd_q     <= FzdNone;
      adno_q    <= 1'b1;
      acc_q     <= '0;
    end else begin
      pv_q      <= pv_d;
      started_q <= started_d;
      tilde_q   <= tilde_d;
      skip_q    <= skip_d;
      off_q     <= off_d;
      tcnt_q    <= tcnt_d;
      tlen_q    <= tlen_d;
      fzd_q     <= fzd_d;
      adno_q    <= adno_d;
      acc_q     <= acc_d;
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      byte_q <= text_byte_i;
      pres_q <= byte_present_i;
      eot_q  <= end_of_text_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/jptp_out_fifo.sv
`default_nettype none

module jptp_out_fifo (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  jptp_pkg::push_t                       push_i,
  input  wire logic                             out_stall_i,
  output logic                                  out_valid_o,
  output jptp_pkg::res_t                        head_o,
  output logic [jptp_pkg::FifoPtrW:0]           level_o
);

  localparam int unsigned PtrW = jptp_pkg::FifoPtrW;

  jptp_pkg::res_t         mem_q [jptp_pkg::FifoDepth];
  logic [PtrW-1:0]        wptr_q, wptr_d;
  logic [PtrW-1:0]        rptr_q, rptr_d;
  logic [PtrW:0]          cnt_q, cnt_d;
  logic [PtrW-1:0]        wptr_nx;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rptr_q];
  assign level_o     = cnt_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign wptr_nx     = wptr_q + PtrW'(1);

  // Pointer and fill level update
  always_comb begin
    wptr_d = wptr_q + PtrW'(push_i.cnt);
    rptr_d = pop ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q + (PtrW+1)'(push_i.cnt) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Up to two result beats written per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.res[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_nx] <= push_i.res[1];
    end
  end

endmodule

`default_nettype wire

// File: sim/json_pointer_token_parser_checker.sv
`timescale 1ns / 100ps

module json_pointer_token_parser_checker #(
  parameter int unsigned INDEX_BITS  = jptp_pkg::IndexBitsDef,
  parameter int unsigned OFFSET_BITS = jptp_pkg::OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  text_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic [15:0] token_number_i,
  input  logic        index_ok_i,
  input  logic [31:0] index_value_i,
  input  logic [1:0]  error_code_i,
  input  logic [15:0] error_offset_i,
  input  logic        last_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  // Largest index value and byte offset the parser can hold
  localparam logic [63:0] IdxMax =
    (INDEX_BITS >= 64) ? {64{1'b1}} : ((64'd1 << INDEX_BITS) - 64'd1);
  localparam int unsigned OffMax =
    (OFFSET_BITS >= 16) ? 65535 : ((1 << OFFSET_BITS) - 1);

  // What the first byte of a token was
  localparam logic [1:0] LeadOther = 2'd0;
  localparam logic [1:0] LeadZero  = 2'd1;
  localparam logic [1:0] LeadDash  = 2'd2;

  // Parser state as tracked on the input side
  logic        in_text    = 1'b0;
  logic        tilde_wait = 1'b0;
  logic        drop_rest  = 1'b0;
  logic [15:0] byte_pos   = '0;
  logic [15:0] token_idx  = '0;
  logic [1:0]  tok_len    = '0;
  logic [1:0]  lead_char  = LeadOther;
  logic        digits_fit = 1'b1;
  logic [63:0] idx_acc    = '0;

  jptp_pkg::res_t token_results_q[$];
  jptp_pkg::res_t want_beat;

  function automatic jptp_pkg::res_t blank_result(input jptp_pkg::kind_e k);
    jptp_pkg::res_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  // Append one expected result beat
  task automatic queue_result(input jptp_pkg::res_t r);
    token_results_q.insert(token_results_q.size(), r);
  endtask

  task automatic clear_token();
    tok_len    = '0;
    lead_char  = LeadOther;
    digits_fit = 1'b1;
    idx_acc    = '0;
  endtask

  task automatic clear_text();
    in_text    = 1'b0;
    tilde_wait = 1'b0;
    drop_rest  = 1'b0;
    byte_pos   = '0;
    token_idx  = '0;
    clear_token();
  endtask

  task automatic add_offset(input int unsigned k);
    int unsigned s;
    s        = byte_pos + k;
    byte_pos = (s > OffMax) ? OffMax[15:0] : s[15:0];
  endtask

  task automatic queue_token_byte(input logic [7:0] ch);
    jptp_pkg::res_t r;
    r              = blank_result(jptp_pkg::KIND_BYTE);
    r.out_byte     = ch;
    r.token_number = token_idx;
    queue_result(r);
  endtask

  // Error beat closes the text; the rest is dropped unless this was its end
  task automatic queue_error(input jptp_pkg::err_e code, input logic [15:0] off,
                             input logic eot);
    jptp_pkg::res_t r;
    r              = blank_result(jptp_pkg::KIND_ERROR);
    r.token_number = token_idx;
    r.error_code   = code;
    r.error_offset = off;
    r.last         = 1'b1;
    queue_result(r);
    clear_text();
    if (!eot) drop_rest = 1'b1;
  endtask

  // Track array-index validity of the token so far
  task automatic feed_index_char(input logic [7:0] ch);
    logic [63:0] digit;
    if (tok_len == 2'd0) begin
      lead_char = (ch == jptp_pkg::CharZero) ? LeadZero :
                  ((ch == jptp_pkg::CharDash) ? LeadDash : LeadOther);
    end
    if (tok_len < 2'd2) tok_len++;
    if (!digits_fit) return;
    if (ch < jptp_pkg::CharZero || ch > jptp_pkg::CharNine) begin
      digits_fit = 1'b0;
      return;
    end
    digit = 64'(ch) - 64'(jptp_pkg::CharZero);
    if (idx_acc > (IdxMax - digit) / 64'd10) begin
      digits_fit = 1'b0;
      return;
    end
    idx_acc = idx_acc * 64'd10 + digit;
  endtask

  task automatic close_token(input logic is_last);
    jptp_pkg::res_t r;
    logic ok;
    ok = (tok_len >= 2'd1) && digits_fit && !(tok_len >= 2'd2 && lead_char == LeadZero);
    r              = blank_result(jptp_pkg::KIND_TOKEN_END);
    r.token_number = token_idx;
    r.index_ok     = ok;
    r.index_value  = ok ? idx_acc[31:0] : 32'd0;
    r.last         = is_last;
    queue_result(r);
    if (token_idx != 16'hFFFF) token_idx++;
    clear_token();
  endtask

  task automatic close_text();
    if (tilde_wait) begin
      queue_error(jptp_pkg::ERR_DANGLING_TILDE, byte_pos, 1'b1);
    end else begin
      close_token(1'b1);
      clear_text();
    end
  endtask

  // Expected results of one input beat
  task automatic predict_text_beat(input logic [7:0] b, input logic here, input logic eot);
    logic [7:0]     ch;
    jptp_pkg::res_t r;
    if (drop_rest) begin
      if (eot) clear_text();
      return;
    end
    if (!in_text) begin
      if (!here) begin
        r      = blank_result(jptp_pkg::KIND_EMPTY);
        r.last = 1'b1;
        queue_result(r);
        clear_text();
        if (!eot) drop_rest = 1'b1;
        return;
      end
      if (b != jptp_pkg::CharSlash) begin
        queue_error(jptp_pkg::ERR_NO_SLASH, 16'd0, eot);
        return;
      end
      clear_text();
      in_text  = 1'b1;
      byte_pos = 16'd1;
      if (eot) close_text();
      return;
    end
    if (!here) begin
      if (eot) close_text();
      return;
    end
    if (tilde_wait) begin
      if (b == jptp_pkg::CharZero || b == jptp_pkg::CharOne) begin
        ch         = (b == jptp_pkg::CharZero) ? jptp_pkg::CharTilde : jptp_pkg::CharSlash;
        tilde_wait = 1'b0;
        add_offset(2);
        queue_token_byte(ch);
        feed_index_char(ch);
        if (eot) close_text();
        return;
      end
      queue_error((b == jptp_pkg::CharSlash) ? jptp_pkg::ERR_DANGLING_TILDE :
                  jptp_pkg::ERR_BAD_ESCAPE, byte_pos, eot);
      return;
    end
    if (b == jptp_pkg::CharSlash) begin
      close_token(1'b0);
      add_offset(1);
      if (eot) close_text();
      return;
    end
    if (b == jptp_pkg::CharTilde) begin
      tilde_wait = 1'b1;
      if (eot) close_text();
      return;
    end
    queue_token_byte(b);
    feed_index_char(b);
    add_offset(1);
    if (eot) close_text();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count_o++;
    end
  endtask

  // Watch both channels; input side first so a beat is predicted on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      token_results_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_text_beat(text_byte_i, byte_present_i, end_of_text_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (token_results_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d", kind_i);
          error_count_o++;
        end else begin
          want_beat = token_results_q.pop_front();
          check_field("kind", want_beat.kind, kind_i);
          check_field("out_byte", want_beat.out_byte, out_byte_i);
          check_field("token_number", want_beat.token_number, token_number_i);
          check_field("index_ok", want_beat.index_ok, index_ok_i);
          check_field("index_value", want_beat.index_value, index_value_i);
          check_field("error_code", want_beat.error_code, error_code_i);
          check_field("error_offset", want_beat.error_offset, error_offset_i);
          check_field("last", want_beat.last, last_i);
          checked_o++;
        end
      end
    end
    pending_o = token_results_q.size();
  end

endmodule

// File: sim/tb_json_pointer_token_parser_unit.sv
`timescale 1ns / 100ps

module tb_json_pointer_token_parser_unit;

  localparam int unsigned RandomBeats = 1400;
  localparam int unsigned QuietLimit  = 1000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i    = '0;
  logic        byte_present_i = 1'b0;
  logic        end_of_text_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [15:0] token_number_o;
  logic        index_ok_o;
  logic [31:0] index_value_o;
  logic [1:0]  error_code_o;
  logic [15:0] error_offset_o;
  logic        last_o;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned checked_results;

  // One text beat waiting to be sent: byte and presence flag
  typedef struct packed {
    logic [7:0] ch;
    logic       here;
  } text_item_t;

  text_item_t  text_q[$];
  int unsigned beats_sent    = 0;
  int unsigned texts_sent    = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned stall_left    = 0;

  json_pointer_token_parser_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .token_number_o (token_number_o),
    .index_ok_o     (index_ok_o),
    .index_value_o  (index_value_o),
    .error_code_o   (error_code_o),
    .error_offset_o (error_offset_o),
    .last_o         (last_o)
  );

  json_pointer_token_parser_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .out_byte_i     (out_byte_o),
    .token_number_i (token_number_o),
    .index_ok_i     (index_ok_o),
    .index_value_i  (index_value_o),
    .error_code_i   (error_code_o),
    .error_offset_i (error_offset_o),
    .last_i         (last_o),
    .error_count_o  (mismatch_count),
    .pending_o      (pending_results),
    .checked_o      (checked_results)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result-side backpressure in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left  <= $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", quiet);
    $display("DONE: errors detected");
    $finish;
  end

  // Present one beat, with an optional idle burst first, and wait for acceptance
  task automatic send_beat(input logic [7:0] b, input logic here, input logic eot);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    byte_present_i <= here;
    end_of_text_i  <= eot;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Append one beat to the text being built
  task automatic add_item(input logic [7:0] ch, input logic here);
    text_q.insert(text_q.size(), {ch, here});
  endtask

  task automatic put_char(input logic [7:0] ch);
    add_item(ch, 1'b1);
  endtask

  task automatic put_absent();
    add_item(8'($urandom), 1'b0);
  endtask

  task automatic put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_char(s.getc(i));
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      send_beat(text_q[i].ch, text_q[i].here, i == text_q.size() - 1);
    end
    text_q.delete();
    texts_sent++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == jptp_pkg::CharSlash || b == jptp_pkg::CharTilde);
    return b;
  endfunction

  // Beats after an error or a leading empty marker; the parser drops them
  task automatic put_junk_tail();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) put_absent();
      else put_char(8'($urandom));
    end
  endtask

  // Decimal run, biased toward the edges of the index range
  task automatic put_number();
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0:       v = $urandom_range(0, 9);
      1:       v = $urandom_range(10, 99999);
      2:       v = {32'd0, $urandom};
      3:       v = 64'hFFFF_FFFE + $urandom_range(0, 3);
      default: v = {$urandom, $urandom};
    endcase
    put_str($sformatf("%0d", v));
  endtask

  task automatic put_token();
    int n;
    int i;
    case ($urandom_range(0, 9))
      0: ;
      1: put_char(jptp_pkg::CharDash);
      2: put_char(jptp_pkg::CharZero);
      3: begin
        put_char(jptp_pkg::CharZero);
        put_number();
      end
      4, 5, 6: put_number();
      7: begin
        if ($urandom_range(0, 1) != 0) begin
          put_number();
          put_char(plain_byte());
        end else begin
          put_char(jptp_pkg::CharDash);
          put_number();
        end
      end
      8: begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 2))
            0:       put_str("~0");
            1:       put_str("~1");
            default: put_char(plain_byte());
          endcase
        end
      end
      default: begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) put_char(plain_byte());
      end
    endcase
  endtask

  task automatic build_good_text();
    int ntok;
    int t;
    put_char(jptp_pkg::CharSlash);
    ntok = $urandom_range(1, 4);
    for (t = 0; t < ntok; t++) begin
      if (t > 0) put_char(jptp_pkg::CharSlash);
      put_token();
    end
    if ($urandom_range(0, 7) == 0) put_char(jptp_pkg::CharSlash);
    // absent beat inside the text or as its closing beat
    if ($urandom_range(0, 9) == 0) begin
      text_q.insert($urandom_range(1, text_q.size()), {8'($urandom), 1'b0});
    end
  endtask

  task automatic build_bad_text();
    logic [7:0] b;
    int n;
    int i;
    case ($urandom_range(0, 5))
      0: begin
        do b = 8'($urandom); while (b == jptp_pkg::CharSlash);
        put_char(b);
        if ($urandom_range(0, 1) != 0) put_junk_tail();
      end
      1: begin
        put_char(jptp_pkg::CharSlash);
        put_token();
        put_char(jptp_pkg::CharTilde);
        do b = 8'($urandom);
        while (b == jptp_pkg::CharZero || b == jptp_pkg::CharOne || b == jptp_pkg::CharSlash);
        put_char(b);
        if ($urandom_range(0, 1) != 0) put_junk_tail();
      end
      2: begin
        put_char(jptp_pkg::CharSlash);
        put_token();
        put_char(jptp_pkg::CharTilde);
        put_char(jptp_pkg::CharSlash);
        if ($urandom_range(0, 1) != 0) put_junk_tail();
      end
      3: begin
        put_char(jptp_pkg::CharSlash);
        put_token();
        put_char(jptp_pkg::CharTilde);
        if ($urandom_range(0, 1) != 0) put_absent();
      end
      4: begin
        put_absent();
        if ($urandom_range(0, 1) != 0) put_junk_tail();
      end
      default: begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0:       put_absent();
            1:       put_char(jptp_pkg::CharSlash);
            2:       put_char(jptp_pkg::CharTilde);
            default: put_char(8'($urandom));
          endcase
        end
      end
    endcase
  endtask

  task automatic pick_idle_mode();
    case ($urandom_range(0, 3))
      0: begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      1: begin
        in_idle_pct   = $urandom_range(5, 40);
        out_stall_pct = 0;
      end
      2: begin
        in_idle_pct   = 0;
        out_stall_pct = $urandom_range(5, 40);
      end
      default: begin
        in_idle_pct   = $urandom_range(5, 40);
        out_stall_pct = $urandom_range(5, 40);
      end
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pointer, every error, escapes, index rules, byte extremes
    in_idle_pct   = 25;
    out_stall_pct = 25;
    put_absent();
    send_text();
    put_char("q");
    put_char(jptp_pkg::CharSlash);
    send_text();
    put_str("/~0~1");
    send_text();
    put_str("/01/0/-/");
    send_text();
    put_str("/~/");
    send_text();
    put_str("/a~");
    send_text();
    put_char(jptp_pkg::CharSlash);
    put_char(8'hFF);
    put_char(jptp_pkg::CharTilde);
    put_char(8'h00);
    send_text();
    put_str("/5");
    put_absent();
    send_text();

    // Random texts, mostly well formed, idle mode changing every few texts
    while (beats_sent < RandomBeats) begin
      if (texts_sent % 8 == 0) pick_idle_mode();
      if ($urandom_range(0, 99) < 75) build_good_text();
      else build_bad_text();
      send_text();
    end

    // Closing stretch at full rate
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (20) begin
      build_good_text();
      send_text();
    end
    in_valid_i <= 1'b0;

    do @(negedge clk_i); while (pending_results != 0);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d pointer texts (%0d beats); checked %0d result beats.",
             texts_sent, beats_sent, checked_results);
    $display("Covered escapes, index limits, all error kinds, empty texts, backpressure.");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
